// File: rtl/core/tsrb_pkg.sv
// tsrb_pkg: shared types and constants of the timestamp reorder buffer
// no dependencies; used by tsrb_cell and timestamp_reorder_buffer_top
package tsrb_pkg;

  localparam int STAMP_W   = 33;
  localparam int PAYLOAD_W = 32;
  localparam int CNT_W     = 4;
  localparam int CFG_W     = 4;
  localparam int IDX_W     = 8;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 4;

  localparam logic [CFG_W-1:0] CAPACITY_RESET = 4'd5;
  localparam logic [CFG_W-1:0] HOLD_BACK_RESET = 4'd0;

  typedef enum logic [IDX_W-1:0] {
    REG_CAPACITY  = 8'd0,
    REG_HOLD_BACK = 8'd1
  } reg_idx_t;

  typedef enum logic {
    CMD_PUT    = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_LATE  = 3'd2,
    ST_DUP   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  // per-cycle command from the top level to every cell
  typedef struct packed {
    logic put_ok;
    logic rem_ok;
  } cell_ctrl_t;

endpackage

// File: rtl/core/timestamp_reorder_buffer_top.sv
// timestamp_reorder_buffer_top: sorted reorder buffer built as a chain of cells
// depends on tsrb_pkg and tsrb_cell
//
// Usage: requests arrive on the in_ stream; in_tuser is the command (put or
// remove), in_tdata carries stamp and payload. Each request yields exactly
// one result on the out_ stream with status and entry_valid in out_tuser and
// the entry stamp, payload and fill count in out_tdata. Puts are inserted at
// their sorted place; puts are refused when full, late or duplicate. A remove
// pops the head while more than hold_back entries are held.
// Configuration writes (capacity_in_use, hold_back) go through the cfg_
// channel, which is always ready; the user must make them only while no
// request is in flight, which the block itself does not enforce. A request is
// registered in the request stage at acceptance, executed against all cells at
// once there, and its result is registered in the result register. Throughput:
// one request per cycle unless out_ stalls, set by the chain's compare-and-shift.
// Reset (rst_n low, synchronous) empties the buffer, forgets the last removed
// stamp and restores capacity 5, hold_back 0. When the receiver stalls, the
// result stays registered, one more request waits in the execute stage and
// in_tready then drops.
module timestamp_reorder_buffer_top #(
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [32:0] stamp, [64:33] payload, [71:65] zero
  input  logic [tsrb_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] cmd
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [32:0] entry_stamp, [64:33] entry_payload, [68:65] fill_count, [71:69] zero
  output logic [tsrb_pkg::OUT_DATA_W-1:0]     out_tdata,
  // [2:0] status, [3] entry_valid
  output logic [tsrb_pkg::OUT_USER_W-1:0]     out_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [tsrb_pkg::IDX_W-1:0]          cfg_index,
  input  logic [tsrb_pkg::CFG_W-1:0]          cfg_data
);
  import tsrb_pkg::*;

  // request stage
  logic                 op_vld_r;
  logic                 op_cmd_r;
  logic [STAMP_W-1:0]   op_stamp_r;
  logic [PAYLOAD_W-1:0] op_payload_r;
  logic                 op_fire;
  logic                 in_fire;

  // state
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [STAMP_W-1:0]   last_stamp_r;
  logic                 last_known_r;
  logic [CFG_W-1:0]     cap_r;
  logic [CFG_W-1:0]     hold_r;

  // result register
  logic                 out_vld_r;
  status_t              out_status_r, status_nxt;
  logic                 out_ev_r, ev_nxt;
  logic [STAMP_W-1:0]   out_stamp_r, es_nxt;
  logic [PAYLOAD_W-1:0] out_payload_r, ep_nxt;
  logic [CNT_W-1:0]     out_fill_r;

  // chain wiring
  logic [DEPTH-1:0]     lt_v, eq_v, occ_v;
  logic [STAMP_W-1:0]   c_stamp   [DEPTH];
  logic [PAYLOAD_W-1:0] c_payload [DEPTH];
  cell_ctrl_t           ctrl;

  logic full, late, dup, avail_now, avail_nxt;

  assign op_fire   = op_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !op_vld_r || op_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (in_fire) begin
      op_vld_r <= 1'b1;
    end else if (op_fire) begin
      op_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_cmd_r     <= in_tuser;
      op_stamp_r   <= in_tdata[STAMP_W-1:0];
      op_payload_r <= in_tdata[STAMP_W+PAYLOAD_W-1:STAMP_W];
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      assign occ_v[g] = (g < int'(held_r));
      if (g == 0) begin : g_head
        tsrb_cell u_cell (
          .clk(clk), .ctrl(ctrl), .occupied(occ_v[g]),
          .req_stamp(op_stamp_r), .req_payload(op_payload_r),
          .prev_lt(1'b1), .prev_stamp(op_stamp_r), .prev_payload(op_payload_r),
          .next_stamp(c_stamp[(g+1) % DEPTH]), .next_payload(c_payload[(g+1) % DEPTH]),
          .lt(lt_v[g]), .eq(eq_v[g]), .stamp(c_stamp[g]), .payload(c_payload[g])
        );
      end else begin : g_body
        // the last cell refills from itself on remove; that slot is then empty
        tsrb_cell u_cell (
          .clk(clk), .ctrl(ctrl), .occupied(occ_v[g]),
          .req_stamp(op_stamp_r), .req_payload(op_payload_r),
          .prev_lt(lt_v[g-1]), .prev_stamp(c_stamp[g-1]),
          .prev_payload(c_payload[g-1]),
          .next_stamp(c_stamp[(g == DEPTH-1) ? g : g+1]),
          .next_payload(c_payload[(g == DEPTH-1) ? g : g+1]),
          .lt(lt_v[g]), .eq(eq_v[g]), .stamp(c_stamp[g]), .payload(c_payload[g])
        );
      end
    end
  endgenerate

  // capacity above the chain length acts as the chain length
  assign full = (int'(held_r) >= DEPTH) || (held_r >= cap_r);
  assign late = last_known_r && (op_stamp_r <= last_stamp_r);
  assign dup  = |eq_v;
  assign avail_now = (held_r > hold_r) && (held_r != '0);

  always_comb begin
    ctrl.put_ok = 1'b0;
    ctrl.rem_ok = 1'b0;
    held_nxt    = held_r;
    status_nxt  = ST_OK;
    if (op_fire) begin
      unique case (cmd_t'(op_cmd_r))
        CMD_PUT: begin
          priority if (full) begin
            status_nxt = ST_FULL;
          end else if (late) begin
            status_nxt = ST_LATE;
          end else if (dup) begin
            status_nxt = ST_DUP;
          end else begin
            ctrl.put_ok = 1'b1;
            held_nxt    = held_r + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (avail_now) begin
            ctrl.rem_ok = 1'b1;
            held_nxt    = held_r - 1'b1;
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        default: status_nxt = ST_EMPTY;
      endcase
    end
  end

  assign avail_nxt = (held_nxt > hold_r) && (held_nxt != '0);

  always_comb begin
    ev_nxt = 1'b0;
    es_nxt = '0;
    ep_nxt = '0;
    if (ctrl.rem_ok) begin
      ev_nxt = 1'b1;
      es_nxt = c_stamp[0];
      ep_nxt = c_payload[0];
    end else if (op_cmd_r == CMD_PUT && avail_nxt) begin
      ev_nxt = 1'b1;
      // new entry becomes head when nothing held sorts below it
      if (ctrl.put_ok && !lt_v[0]) begin
        es_nxt = op_stamp_r;
        ep_nxt = op_payload_r;
      end else begin
        es_nxt = c_stamp[0];
        ep_nxt = c_payload[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r       <= '0;
      last_known_r <= 1'b0;
      last_stamp_r <= '0;
      cap_r        <= CAPACITY_RESET;
      hold_r       <= HOLD_BACK_RESET;
      out_vld_r    <= 1'b0;
    end else begin
      held_r <= held_nxt;
      if (ctrl.rem_ok) begin
        last_known_r <= 1'b1;
        last_stamp_r <= c_stamp[0];
      end
      if (cfg_valid) begin
        if (cfg_index == REG_CAPACITY) begin
          cap_r <= cfg_data;
        end else if (cfg_index == REG_HOLD_BACK) begin
          hold_r <= cfg_data;
        end
      end
      if (op_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_fire) begin
      out_status_r  <= status_nxt;
      out_ev_r      <= ev_nxt;
      out_stamp_r   <= es_nxt;
      out_payload_r <= ep_nxt;
      out_fill_r    <= held_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tuser  = {out_ev_r, out_status_r};
  assign out_tdata  = {{(OUT_DATA_W-STAMP_W-PAYLOAD_W-CNT_W){1'b0}},
                       out_fill_r, out_payload_r, out_stamp_r};

endmodule

// File: rtl/core/tsrb_cell.sv
// tsrb_cell: one slot of the sorted shift chain, holding a stamp and payload
// compares its stamp with the request and shifts up or down; uses tsrb_pkg
module tsrb_cell (
  input  logic                               clk,
  input  tsrb_pkg::cell_ctrl_t               ctrl,
  input  logic                               occupied,
  input  logic [tsrb_pkg::STAMP_W-1:0]       req_stamp,
  input  logic [tsrb_pkg::PAYLOAD_W-1:0]     req_payload,
  input  logic                               prev_lt,
  input  logic [tsrb_pkg::STAMP_W-1:0]       prev_stamp,
  input  logic [tsrb_pkg::PAYLOAD_W-1:0]     prev_payload,
  input  logic [tsrb_pkg::STAMP_W-1:0]       next_stamp,
  input  logic [tsrb_pkg::PAYLOAD_W-1:0]     next_payload,
  output logic                               lt,
  output logic                               eq,
  output logic [tsrb_pkg::STAMP_W-1:0]       stamp,
  output logic [tsrb_pkg::PAYLOAD_W-1:0]     payload
);
  import tsrb_pkg::*;

  logic [STAMP_W-1:0]   stamp_r;
  logic [PAYLOAD_W-1:0] payload_r;
  logic [STAMP_W-1:0]   stamp_nxt;
  logic [PAYLOAD_W-1:0] payload_nxt;

  assign lt      = occupied && (stamp_r < req_stamp);
  assign eq      = occupied && (stamp_r == req_stamp);
  assign stamp   = stamp_r;
  assign payload = payload_r;

  always_comb begin
    stamp_nxt   = stamp_r;
    payload_nxt = payload_r;
    priority if (ctrl.rem_ok) begin
      stamp_nxt   = next_stamp;
      payload_nxt = next_payload;
    end else if (ctrl.put_ok && !lt) begin
      // first slot not below the new stamp takes it, later ones move up
      if (prev_lt) begin
        stamp_nxt   = req_stamp;
        payload_nxt = req_payload;
      end else begin
        stamp_nxt   = prev_stamp;
        payload_nxt = prev_payload;
      end
    end else begin
      stamp_nxt   = stamp_r;
      payload_nxt = payload_r;
    end
  end

  always_ff @(posedge clk) begin
    stamp_r   <= stamp_nxt;
    payload_r <= payload_nxt;
  end

endmodule
